/* rtl/vnh_pkg.sv */
// Package for the value noise height generator.
// Holds offsets, the cosine weight table, the blend helper and the stage enable struct.
// No dependencies.
`default_nettype none
package vnh_pkg;

	localparam int unsigned CW = 21;  // coordinate width after offsets

	localparam logic [CW-1:0] OFF_X  = 21'd932731;
	localparam logic [CW-1:0] OFF_Y  = 21'd556238;
	localparam logic [CW-1:0] OCT4_X = 21'd45365;
	localparam logic [CW-1:0] OCT4_Y = 21'd91923;
	localparam logic [CW-1:0] OCT2_X = 21'd10294;
	localparam logic [CW-1:0] OCT2_Y = 21'd37821;

	localparam logic [31:0] HASH_MUL_A = 32'd15731;
	localparam logic [31:0] HASH_ADD_A = 32'd789221;
	localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
	localparam logic [31:0] ROW_MUL    = 32'd57;

	localparam logic [5:0] HEIGHT_BASE = 6'd35;
	localparam logic [5:0] HEIGHT_MIN  = 6'd10;
	localparam logic [5:0] HEIGHT_MAX  = 6'd60;
	localparam logic [12:0] RECIP_TEN  = 13'd6554;  // ceil(65536/10)

	// stage enables shared by the hash and octave pipelines
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} vnh_en_t;

	function automatic logic [16:0] cos_weight(input logic [1:0] idx);
		logic [16:0] w;
		unique case (idx)
			2'd0: w = 17'd0;
			2'd1: w = 17'd9598;
			2'd2: w = 17'd32768;
			default: w = 17'd55938;
		endcase
		return w;
	endfunction

	// ((a*(65536-w))>>16) + ((b*w)>>16), result stays within 8 bits
	function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
		input logic [1:0] idx);
		logic [16:0] w;
		logic [24:0] pa;
		logic [24:0] pb;
		logic [9:0]  sum;
		w   = cos_weight(idx);
		pa  = 25'(a) * 25'(17'h10000 - w);
		pb  = 25'(b) * 25'(w);
		sum = 10'(pa[24:16]) + 10'(pb[24:16]);
		return sum[7:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/vnh_hash.sv */
// Four-stage lattice point hash: 32-bit wrapping polynomial, 8-bit value out.
// Depends on vnh_pkg (constants, enable struct).
`default_nettype none
module vnh_hash
	import vnh_pkg::*;
(
	input  wire logic        clk,
	input  wire vnh_en_t     en,
	input  wire logic [31:0] px,
	input  wire logic [31:0] py,
	output logic      [7:0]  val_s5
);
	logic [31:0] n_c;
	logic [31:0] n_s2;
	logic [31:0] n_s3;
	logic [31:0] sq_s3;
	logic [31:0] n_s4;
	logic [31:0] t_s4;
	logic [31:0] h_c;

	always_comb begin
		n_c = px + py * ROW_MUL;
		n_c = (n_c << 13) ^ n_c;
	end

	assign h_c = n_s4 * t_s4 + HASH_ADD_B;

	always_ff @(posedge clk) begin
		if (en.s2) n_s2 <= n_c;
		if (en.s3) begin
			n_s3  <= n_s2;
			sq_s3 <= n_s2 * n_s2;
		end
		if (en.s4) begin
			n_s4 <= n_s3;
			t_s4 <= sq_s3 * HASH_MUL_A + HASH_ADD_A;
		end
		if (en.s5) val_s5 <= h_c[26:19];
	end
endmodule
`default_nettype wire

/* rtl/vnh_octave.sv */
// One noise octave: 4x4 lattice hashes, 3x3 smoothing, two cosine blend stages.
// Depends on vnh_pkg and vnh_hash.
`default_nettype none
module vnh_octave
	import vnh_pkg::*;
(
	input  wire logic          clk,
	input  wire vnh_en_t       en,
	input  wire logic [CW-1:0] cx,
	input  wire logic [CW-1:0] cy,
	input  wire logic [1:0]    wxi,
	input  wire logic [1:0]    wyi,
	output logic      [7:0]    noise_s8
);
	logic [7:0] val [4][4];   // [row][col], grid offset -1..2
	logic [1:0] wxi_s2, wxi_s3, wxi_s4, wxi_s5, wxi_s6;
	logic [1:0] wyi_s2, wyi_s3, wyi_s4, wyi_s5, wyi_s6, wyi_s7;
	logic [7:0] cell_c [4];
	logic [7:0] cell_s6 [4];
	logic [7:0] ix_s7 [2];

	for (genvar gy = 0; gy < 4; gy++) begin : g_row
		for (genvar gx = 0; gx < 4; gx++) begin : g_col
			vnh_hash u_hash (
				.clk    (clk),
				.en     (en),
				.px     (32'(cx) + 32'(gx) - 32'd1),
				.py     (32'(cy) + 32'(gy) - 32'd1),
				.val_s5 (val[gy][gx])
			);
		end
	end

	// cell k: col k[0], row k[1]; its center sits at grid (row+1, col+1)
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [9:0] c;
			logic [9:0] s;
			logic [9:0] tot;
			int r;
			int q;
			r = k / 2 + 1;
			q = k % 2 + 1;
			c = 10'(val[r-1][q-1]) + 10'(val[r-1][q+1])
			  + 10'(val[r+1][q-1]) + 10'(val[r+1][q+1]);
			s = 10'(val[r][q-1]) + 10'(val[r][q+1])
			  + 10'(val[r-1][q]) + 10'(val[r+1][q]);
			tot = 10'(c[9:4]) + 10'(s[9:3]) + 10'(val[r][q][7:2]);
			cell_c[k] = tot[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin wxi_s2 <= wxi;    wyi_s2 <= wyi;    end
		if (en.s3) begin wxi_s3 <= wxi_s2; wyi_s3 <= wyi_s2; end
		if (en.s4) begin wxi_s4 <= wxi_s3; wyi_s4 <= wyi_s3; end
		if (en.s5) begin wxi_s5 <= wxi_s4; wyi_s5 <= wyi_s4; end
		if (en.s6) begin
			wxi_s6  <= wxi_s5;
			wyi_s6  <= wyi_s5;
			cell_s6 <= cell_c;
		end
		if (en.s7) begin
			wyi_s7   <= wyi_s6;
			ix_s7[0] <= blend(cell_s6[0], cell_s6[1], wxi_s6);
			ix_s7[1] <= blend(cell_s6[2], cell_s6[3], wxi_s6);
		end
		if (en.s8) noise_s8 <= blend(ix_s7[0], ix_s7[1], wyi_s7);
	end
endmodule
`default_nettype wire

/* rtl/value_noise_height_generator_top.sv */
// Top level of the value noise height generator: offsets, three octaves, final scaling.
// Depends on vnh_pkg and vnh_octave.
`default_nettype none
// The block takes one coordinate transfer per clock while in_stall is low and returns
// one ground height per coordinate, in order. The ten register stages are: offset and
// cell split, four stages of the lattice hash (two full 32-bit multiplies), smoothing,
// two cosine blend stages, octave sum with sign split, and the divide by ten with
// clamp, which is the output register. A stall on the output freezes only the full
// stages behind it; empty stages keep filling, so the input keeps accepting until the
// pipeline is packed.
module value_noise_height_generator_top
	import vnh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] world_x,
	input  wire logic [15:0] world_y,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [5:0]  ground_height
);
	localparam int NS = 10;

	logic [NS:1] vld_q;
	logic [NS:1] en;
	vnh_en_t     oct_en;

	logic [CW-1:0] x_c, y_c, x4_c, y4_c, x2_c, y2_c;
	logic [CW-1:0] cx4_s1, cy4_s1, cx2_s1, cy2_s1, cx1_s1, cy1_s1;
	logic [1:0]    wx4_s1, wy4_s1, wx2_s1, wy2_s1;
	logic [7:0]    n4_s8, n2_s8, n1_s8;
	logic signed [9:0] h_c;
	logic signed [11:0] h3_c;
	logic [9:0]    mag_s9;
	logic          neg_s9;
	logic [22:0]   prod_c;
	logic [6:0]    quo_c;
	logic signed [8:0] g_c;
	logic [5:0]    gh_c;

	// advance a stage when it is empty or the stage after it advances
	always_comb begin
		en[NS] = !vld_q[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) en[k] = !vld_q[k] || en[k+1];
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[NS];
	assign oct_en    = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5],
	                     s6: en[6], s7: en[7], s8: en[8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= NS; k++) if (en[k]) vld_q[k] <= vld_q[k-1];
		end
	end

	// offset coordinates stay positive, so cell index is a plain shift
	always_comb begin
		x_c  = CW'(world_x) + OFF_X;
		y_c  = CW'(world_y) + OFF_Y;
		x4_c = x_c + OCT4_X;
		y4_c = y_c + OCT4_Y;
		x2_c = x_c + OCT2_X;
		y2_c = y_c + OCT2_Y;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cx4_s1 <= x4_c >> 2;
			cy4_s1 <= y4_c >> 2;
			wx4_s1 <= x4_c[1:0];
			wy4_s1 <= y4_c[1:0];
			cx2_s1 <= x2_c >> 1;
			cy2_s1 <= y2_c >> 1;
			wx2_s1 <= {x2_c[0], 1'b0};
			wy2_s1 <= {y2_c[0], 1'b0};
			cx1_s1 <= x_c;
			cy1_s1 <= y_c;
		end
	end

	vnh_octave u_oct4 (
		.clk (clk), .en (oct_en), .cx (cx4_s1), .cy (cy4_s1),
		.wxi (wx4_s1), .wyi (wy4_s1), .noise_s8 (n4_s8)
	);
	vnh_octave u_oct2 (
		.clk (clk), .en (oct_en), .cx (cx2_s1), .cy (cy2_s1),
		.wxi (wx2_s1), .wyi (wy2_s1), .noise_s8 (n2_s8)
	);
	// unit scale: local position is always zero, so the blend weight is zero
	vnh_octave u_oct1 (
		.clk (clk), .en (oct_en), .cx (cx1_s1), .cy (cy1_s1),
		.wxi (2'd0), .wyi (2'd0), .noise_s8 (n1_s8)
	);

	// octave sum, then split into sign and magnitude of 3*h
	always_comb begin
		h_c  = $signed(10'(n4_s8)) + $signed(10'(n2_s8[7:1])) + $signed(10'(n1_s8[7:2]))
		     - 10'sd224;
		h3_c = 12'(h_c) * 12'sd3;
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			neg_s9 <= h3_c[11];
			mag_s9 <= h3_c[11] ? 10'(-h3_c) : 10'(h3_c);
		end
	end

	// magnitude below 700: reciprocal multiply gives the exact truncated quotient
	always_comb begin
		prod_c = 23'(mag_s9) * 23'(RECIP_TEN);
		quo_c  = prod_c[22:16];
		g_c    = neg_s9 ? 9'(HEIGHT_BASE) - 9'(quo_c) : 9'(HEIGHT_BASE) + 9'(quo_c);
		priority if (g_c < $signed(9'(HEIGHT_MIN))) gh_c = HEIGHT_MIN;
		else if (g_c > $signed(9'(HEIGHT_MAX)))     gh_c = HEIGHT_MAX;
		else                                        gh_c = g_c[5:0];
	end

	always_ff @(posedge clk) begin
		if (en[NS]) ground_height <= gh_c;
	end

	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ground_height >= HEIGHT_MIN && ground_height <= HEIGHT_MAX))
		else $error("ground_height out of range");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[1])
		else $error("accepted transfer lost at first stage");
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> !in_stall)
		else $error("input stalled while first stage empty");
	a_frozen_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[9] && vld_q[NS] && out_stall) |=> vld_q[9])
		else $error("stage nine dropped under stall");
endmodule
`default_nettype wire
